@@ hdl/salru_pkg.sv @@
// Shared types, codes and defaults for the set-associative tag store with LRU ages.
package salru_pkg;

    localparam int DEF_ADDR_BITS   = 32;
    localparam int DEF_BLOCK_BYTES = 64;
    localparam int DEF_SETS        = 64;
    localparam int DEF_WAYS        = 4;
    localparam int DEF_AGE_BITS    = 8;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FILL   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ACT_HIT  = 2'd0,
        ACT_MISS = 2'd1,
        ACT_FILL = 2'd2
    } action_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] address;
        logic [6:0]  req_size;
    } req_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] out_address;
        logic [6:0]  out_size;
        logic [1:0]  way_used;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } stat_t;

endpackage

@@ hdl/salru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/salru_ctrl.sv @@
// Controller state machine: reset clearing pass, transaction accept, lookup/update.
module salru_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  salru_pkg::stat_t  stat,
    output salru_pkg::cmd_t   cmd,
    output logic              busy
);

    import salru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_LOOKUP:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/salru_dp.sv @@
// Datapath: address split, set RAM, tag compare, victim pick, age update, result register.
module salru_dp #(
    parameter int ADDR_BITS   = salru_pkg::DEF_ADDR_BITS,
    parameter int BLOCK_BYTES = salru_pkg::DEF_BLOCK_BYTES,
    parameter int SETS        = salru_pkg::DEF_SETS,
    parameter int WAYS        = salru_pkg::DEF_WAYS,
    parameter int AGE_BITS    = salru_pkg::DEF_AGE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  salru_pkg::cmd_t   cmd,
    input  salru_pkg::req_t   req,
    output salru_pkg::stat_t  stat,
    output logic              done,
    output salru_pkg::rsp_t   rsp
);

    import salru_pkg::*;

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EFF_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int TAG_RAW  = EFF_BITS - OFF_BITS - SET_BITS;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int ENTRY_W  = 1 + TAG_W + AGE_BITS;
    localparam int ROW_W    = WAYS * ENTRY_W;
    localparam logic [32:0] MASK_33  = (33'd1 << EFF_BITS) - 33'd1;
    localparam logic [31:0] ADDR_MASK = MASK_33[31:0];
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SETS - 1);

    req_t              req_reg;
    logic [IDX_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  clr_cnt_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              done_reg;

    logic [31:0]       addr_m;
    logic [31:0]       set_full;
    logic [31:0]       tag_full;
    logic [IDX_W-1:0]  set_in;
    logic [TAG_W-1:0]  tag_in;

    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  new_row;
    logic [ROW_W-1:0]  wr_row;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;

    logic                ent_valid [WAYS];
    logic [TAG_W-1:0]    ent_tag   [WAYS];
    logic [AGE_BITS-1:0] ent_age   [WAYS];
    logic [WAYS-1:0]     hit_vec;
    logic                hit_any;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    vic_way;
    logic [AGE_BITS-1:0] vic_age;
    logic [WAY_W-1:0]    use_way;
    logic [WAY_W:0]      way_x;
    logic                is_fill;
    logic                do_write;

    // address split
    always_comb
    begin
        addr_m   = req.address & ADDR_MASK;
        set_full = addr_m >> OFF_BITS;
        tag_full = addr_m >> (OFF_BITS + SET_BITS);
        set_in   = (SET_BITS > 0) ? set_full[IDX_W-1:0] : '0;
        tag_in   = tag_full[TAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
    end

    // clearing pass counter
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == LAST_SET);

    // row layout per way: {valid, tag, age}
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            ent_valid[w] = rd_row[w*ENTRY_W + ENTRY_W - 1];
            ent_tag[w]   = rd_row[w*ENTRY_W + AGE_BITS +: TAG_W];
            ent_age[w]   = rd_row[w*ENTRY_W +: AGE_BITS];
            hit_vec[w]   = ent_valid[w] && (ent_tag[w] == tag_reg);
        end
    end

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // oldest way, lowest index on a tie
    always_comb
    begin
        vic_way = '0;
        vic_age = ent_age[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (ent_age[w] > vic_age)
            begin
                vic_age = ent_age[w];
                vic_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        is_fill  = (req_reg.op == OP_FILL);
        use_way  = hit_any ? hit_way : (is_fill ? vic_way : '0);
        do_write = cmd.update && (is_fill || hit_any);
        new_row  = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (is_fill && !hit_any && (WAY_W'(w) == vic_way))
            begin
                new_row[w*ENTRY_W + ENTRY_W - 1]      = 1'b1;
                new_row[w*ENTRY_W + AGE_BITS +: TAG_W] = tag_reg;
            end
            if (WAY_W'(w) == use_way)
            begin
                new_row[w*ENTRY_W +: AGE_BITS] = '0;
            end
            else if (ent_age[w] != AGE_MAX)
            begin
                new_row[w*ENTRY_W +: AGE_BITS] = ent_age[w] + 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_en   = cmd.clear || do_write;
        wr_addr = cmd.clear ? clr_cnt_reg : set_reg;
        wr_row  = cmd.clear ? '0 : new_row;
    end

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_row),
        .re    (cmd.load),
        .raddr (set_in),
        .rdata (rd_row)
    );

    // result
    always_comb
    begin
        way_x                = {1'b0, use_way};
        rsp_next.action      = is_fill ? ACT_FILL : (hit_any ? ACT_HIT : ACT_MISS);
        rsp_next.out_address = req_reg.address;
        rsp_next.out_size    = req_reg.req_size;
        rsp_next.way_used    = way_x[1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ hdl/set_assoc_cache_tags_lru.sv @@
// Top level of the set-associative cache tag store with age-counter LRU replacement.
//
//  channel   handshake                 payload
//  request   start in, busy out        req  (op, address, req_size)
//  result    done out, one-cycle       rsp  (action, out_address, out_size, way_used)
//
// In one transaction the set row is read from the row RAM
// (registered read), then compared, updated and written back in the next cycle.
// The result strobe follows in the cycle after that; busy drops as it appears.
// After reset a clearing pass writes every set row with busy high.
// The result side has no stall; done is high for exactly one cycle per transaction.
module set_assoc_cache_tags_lru #(
    parameter int ADDR_BITS   = salru_pkg::DEF_ADDR_BITS,
    parameter int BLOCK_BYTES = salru_pkg::DEF_BLOCK_BYTES,
    parameter int SETS        = salru_pkg::DEF_SETS,
    parameter int WAYS        = salru_pkg::DEF_WAYS,
    parameter int AGE_BITS    = salru_pkg::DEF_AGE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  salru_pkg::req_t  req,
    output logic             done,
    output salru_pkg::rsp_t  rsp
);

    import salru_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    salru_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    salru_dp #(
        .ADDR_BITS   (ADDR_BITS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .SETS        (SETS),
        .WAYS        (WAYS),
        .AGE_BITS    (AGE_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
